// ----- rtl/hvn_pkg.sv -----
`timescale 1ns / 1ps
// Shared constants and types for the height-map vertex normal unit.
// No dependencies; every other file of the block imports this package.
package hvn_pkg;

	localparam int HEIGHT_W         = 16;
	localparam int SPACING_W        = 16;
	localparam int NORMAL_W         = 16;
	localparam int CFG_IDX_W        = 8;
	localparam int CFG_DATA_W       = 16;
	localparam int UNIT_FRAC        = 30;
	localparam int NORMAL_FRAC_DEF  = 14;
	// Signed width of a vector component entering normalization.
	localparam int VEC_W            = 34;
	// Normalized magnitudes lie in [0, 2^31); the root of their square sum fits 32 bits.
	localparam int NRM_W            = 31;
	localparam int ROOT_W           = 32;
	localparam int RAD_W            = 2 * ROOT_W;

	localparam logic [CFG_IDX_W-1:0] REG_X_SPACING = CFG_IDX_W'(0);
	localparam logic [CFG_IDX_W-1:0] REG_Z_SPACING = CFG_IDX_W'(1);
	localparam logic [SPACING_W-1:0] SPACING_RESET = SPACING_W'(256);

	typedef logic signed [HEIGHT_W-1:0] height_t;
	typedef logic signed [NORMAL_W-1:0] normal_t;
	typedef logic signed [VEC_W-1:0]    vcomp_t;

endpackage

// ----- rtl/hvn_ifs.sv -----
`timescale 1ns / 1ps
// Valid/ready channel interfaces of the vertex normal unit: height request,
// normal result and configuration write. Depends on hvn_pkg.
interface hvn_in_if;
	import hvn_pkg::*;
	logic    valid;
	logic    ready;
	height_t height_center;
	height_t height_east;
	height_t height_north;
	height_t height_west;
	height_t height_south;
	modport source (output valid, height_center, height_east, height_north, height_west,
		height_south, input ready);
	modport sink (input valid, height_center, height_east, height_north, height_west,
		height_south, output ready);
endinterface

interface hvn_out_if;
	import hvn_pkg::*;
	logic    valid;
	logic    ready;
	normal_t normal_x;
	normal_t normal_y;
	normal_t normal_z;
	modport source (output valid, normal_x, normal_y, normal_z, input ready);
	modport sink (input valid, normal_x, normal_y, normal_z, output ready);
endinterface

interface hvn_cfg_if;
	import hvn_pkg::*;
	logic                  valid;
	logic                  ready;
	logic [CFG_IDX_W-1:0]  index;
	logic [CFG_DATA_W-1:0] data;
	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface

// ----- rtl/hvn_unitize.sv -----
`timescale 1ns / 1ps
// Pipelined vector normalization: magnitude scaling, square sum, bit-serial
// square root and restoring division, one stage per step. Depends on hvn_pkg.
module hvn_unitize #(
	parameter int FRAC = hvn_pkg::UNIT_FRAC
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       en,
	input  logic                       in_valid,
	input  hvn_pkg::vcomp_t            in_vec [3],
	output logic                       out_valid,
	output logic signed [FRAC+1:0]     out_vec [3]
);
	import hvn_pkg::*;

	localparam int MAG_W     = VEC_W - 1;
	localparam int POS_W     = $clog2(MAG_W);
	localparam int TOP_BIT   = NRM_W - 1;
	localparam int RSH_W     = $clog2(MAG_W - TOP_BIT);
	localparam int LSH_W     = $clog2(TOP_BIT + 1);
	localparam int SQR_W     = 2 * NRM_W;
	localparam int REM_W     = ROOT_W + 4;
	localparam int SQ_STEPS  = ROOT_W;
	localparam int DIV_STEPS = FRAC + 1;
	localparam int Q_W       = FRAC + 1;
	localparam int NUM_W     = NRM_W + FRAC + 1;
	localparam int DREM_W    = ROOT_W + 1;
	localparam int OUT_W     = FRAC + 2;
	localparam logic [Q_W-1:0] ONE = Q_W'(1) << FRAC;

	// Magnitudes and signs.
	logic             v_s1;
	logic [MAG_W-1:0] mag_s1 [3];
	logic [2:0]       neg_s1;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s1 <= 1'b0;
		else if (en) v_s1 <= in_valid;
	end
	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < 3; i++) begin
				neg_s1[i] <= in_vec[i][VEC_W-1];
				mag_s1[i] <= MAG_W'(in_vec[i][VEC_W-1] ? -in_vec[i] : in_vec[i]);
			end
		end
	end

	// Largest magnitude.
	logic             v_s2;
	logic [MAG_W-1:0] mag_s2 [3];
	logic [2:0]       neg_s2;
	logic [MAG_W-1:0] mx_s2;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s2 <= 1'b0;
		else if (en) v_s2 <= v_s1;
	end
	always_ff @(posedge clk) begin
		if (en) begin
			mag_s2 <= mag_s1;
			neg_s2 <= neg_s1;
			if (mag_s1[0] >= mag_s1[1] && mag_s1[0] >= mag_s1[2]) mx_s2 <= mag_s1[0];
			else if (mag_s1[1] >= mag_s1[2]) mx_s2 <= mag_s1[1];
			else mx_s2 <= mag_s1[2];
		end
	end

	// Leading-one position gives the common shift that puts the maximum in [2^30, 2^31).
	logic [POS_W-1:0] lead_pos;
	always_comb begin
		lead_pos = '0;
		for (int b = 0; b < MAG_W; b++) begin
			if (mx_s2[b]) lead_pos = POS_W'(b);
		end
	end

	logic             v_s3;
	logic [MAG_W-1:0] mag_s3 [3];
	logic [2:0]       neg_s3;
	logic             zero_s3;
	logic [RSH_W-1:0] rsh_s3;
	logic [LSH_W-1:0] lsh_s3;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s3 <= 1'b0;
		else if (en) v_s3 <= v_s2;
	end
	always_ff @(posedge clk) begin
		if (en) begin
			mag_s3  <= mag_s2;
			neg_s3  <= neg_s2;
			zero_s3 <= (mx_s2 == '0);
			rsh_s3  <= (lead_pos > POS_W'(TOP_BIT)) ? RSH_W'(lead_pos - POS_W'(TOP_BIT)) : '0;
			lsh_s3  <= (lead_pos < POS_W'(TOP_BIT)) ? LSH_W'(POS_W'(TOP_BIT) - lead_pos) : '0;
		end
	end

	// Scaled magnitudes.
	logic             v_s4;
	logic [NRM_W-1:0] nrm_s4 [3];
	logic [2:0]       neg_s4;
	logic             zero_s4;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s4 <= 1'b0;
		else if (en) v_s4 <= v_s3;
	end
	always_ff @(posedge clk) begin
		if (en) begin
			neg_s4  <= neg_s3;
			zero_s4 <= zero_s3;
			for (int i = 0; i < 3; i++)
				nrm_s4[i] <= NRM_W'((RAD_W'(mag_s3[i]) >> rsh_s3) << lsh_s3);
		end
	end

	// Squares.
	logic             v_s5;
	logic [NRM_W-1:0] nrm_s5 [3];
	logic [SQR_W-1:0] sqr_s5 [3];
	logic [2:0]       neg_s5;
	logic             zero_s5;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s5 <= 1'b0;
		else if (en) v_s5 <= v_s4;
	end
	always_ff @(posedge clk) begin
		if (en) begin
			nrm_s5  <= nrm_s4;
			neg_s5  <= neg_s4;
			zero_s5 <= zero_s4;
			for (int i = 0; i < 3; i++)
				sqr_s5[i] <= SQR_W'(nrm_s4[i]) * SQR_W'(nrm_s4[i]);
		end
	end

	// Square root, two radicand bits per stage. Entry zero holds the square sum.
	logic             sq_v    [SQ_STEPS+1];
	logic [RAD_W-1:0] sq_rad  [SQ_STEPS+1];
	logic [REM_W-1:0] sq_rem  [SQ_STEPS+1];
	logic [ROOT_W-1:0] sq_root [SQ_STEPS+1];
	logic [NRM_W-1:0] sq_nrm  [SQ_STEPS+1][3];
	logic [2:0]       sq_neg  [SQ_STEPS+1];
	logic             sq_zero [SQ_STEPS+1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) sq_v[0] <= 1'b0;
		else if (en) sq_v[0] <= v_s5;
	end
	always_ff @(posedge clk) begin
		if (en) begin
			sq_rad[0]  <= RAD_W'(sqr_s5[0]) + RAD_W'(sqr_s5[1]) + RAD_W'(sqr_s5[2]);
			sq_rem[0]  <= '0;
			sq_root[0] <= '0;
			sq_nrm[0]  <= nrm_s5;
			sq_neg[0]  <= neg_s5;
			sq_zero[0] <= zero_s5;
		end
	end

	for (genvar k = 0; k < SQ_STEPS; k++) begin : g_sqrt
		logic [REM_W-1:0] rem4;
		logic [REM_W-1:0] trial;
		assign rem4  = {sq_rem[k][REM_W-3:0], sq_rad[k][RAD_W-1 -: 2]};
		assign trial = REM_W'({sq_root[k], 2'b01});

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) sq_v[k+1] <= 1'b0;
			else if (en) sq_v[k+1] <= sq_v[k];
		end
		always_ff @(posedge clk) begin
			if (en) begin
				sq_rad[k+1]  <= sq_rad[k] << 2;
				sq_nrm[k+1]  <= sq_nrm[k];
				sq_neg[k+1]  <= sq_neg[k];
				sq_zero[k+1] <= sq_zero[k];
				if (rem4 >= trial) begin
					sq_rem[k+1]  <= rem4 - trial;
					sq_root[k+1] <= {sq_root[k][ROOT_W-2:0], 1'b1};
				end else begin
					sq_rem[k+1]  <= rem4;
					sq_root[k+1] <= {sq_root[k][ROOT_W-2:0], 1'b0};
				end
			end
		end
	end

	// Division of each scaled magnitude (with half the root added for rounding) by the root.
	logic              dv_v    [DIV_STEPS+1];
	logic [DREM_W-1:0] dv_rem  [DIV_STEPS+1][3];
	logic [Q_W-1:0]    dv_low  [DIV_STEPS+1][3];
	logic [Q_W-1:0]    dv_q    [DIV_STEPS+1][3];
	logic [ROOT_W-1:0] dv_r    [DIV_STEPS+1];
	logic [2:0]        dv_neg  [DIV_STEPS+1];
	logic              dv_zero [DIV_STEPS+1];

	logic [NUM_W-1:0] num [3];
	always_comb begin
		for (int i = 0; i < 3; i++)
			num[i] = (NUM_W'(sq_nrm[SQ_STEPS][i]) << FRAC) + NUM_W'(sq_root[SQ_STEPS] >> 1);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) dv_v[0] <= 1'b0;
		else if (en) dv_v[0] <= sq_v[SQ_STEPS];
	end
	always_ff @(posedge clk) begin
		if (en) begin
			dv_r[0]    <= sq_root[SQ_STEPS];
			dv_neg[0]  <= sq_neg[SQ_STEPS];
			dv_zero[0] <= sq_zero[SQ_STEPS];
			for (int i = 0; i < 3; i++) begin
				dv_rem[0][i] <= DREM_W'(num[i] >> (FRAC + 1));
				dv_low[0][i] <= num[i][FRAC:0];
				dv_q[0][i]   <= '0;
			end
		end
	end

	for (genvar j = 0; j < DIV_STEPS; j++) begin : g_div
		logic [DREM_W-1:0] part [3];
		always_comb begin
			for (int i = 0; i < 3; i++)
				part[i] = {dv_rem[j][i][DREM_W-2:0], dv_low[j][i][Q_W-1]};
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) dv_v[j+1] <= 1'b0;
			else if (en) dv_v[j+1] <= dv_v[j];
		end
		always_ff @(posedge clk) begin
			if (en) begin
				dv_r[j+1]    <= dv_r[j];
				dv_neg[j+1]  <= dv_neg[j];
				dv_zero[j+1] <= dv_zero[j];
				for (int i = 0; i < 3; i++) begin
					dv_low[j+1][i] <= dv_low[j][i] << 1;
					if (part[i] >= DREM_W'(dv_r[j])) begin
						dv_rem[j+1][i] <= part[i] - DREM_W'(dv_r[j]);
						dv_q[j+1][i]   <= {dv_q[j][i][Q_W-2:0], 1'b1};
					end else begin
						dv_rem[j+1][i] <= part[i];
						dv_q[j+1][i]   <= {dv_q[j][i][Q_W-2:0], 1'b0};
					end
				end
			end
		end
	end

	// Clamp, restore signs; an all-zero vector maps to the up vector.
	logic [OUT_W-1:0] qmag [3];
	always_comb begin
		for (int i = 0; i < 3; i++)
			qmag[i] = OUT_W'((dv_q[DIV_STEPS][i] > ONE) ? ONE : dv_q[DIV_STEPS][i]);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) out_valid <= 1'b0;
		else if (en) out_valid <= dv_v[DIV_STEPS];
	end
	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < 3; i++) begin
				if (dv_zero[DIV_STEPS]) out_vec[i] <= (i == 1) ? OUT_W'(ONE) : '0;
				else if (dv_neg[DIV_STEPS][i]) out_vec[i] <= -$signed(qmag[i]);
				else out_vec[i] <= $signed(qmag[i]);
			end
		end
	end

endmodule

// ----- rtl/heightmap_vertex_normal_unit.sv -----
`timescale 1ns / 1ps
// Height-map vertex normal unit. Each request passes through two normalization
// pipelines in series, with one square-root bit and one quotient bit per stage. Throughput
// is one request per cycle while the output skid register holds no stalled result.
// Reset clears all valid bits and the output skid register and loads both spacings
// with 256 (1.0 in Q8.8). Depends on hvn_pkg, hvn_ifs and hvn_unitize.
module heightmap_vertex_normal_unit #(
	parameter int NORMAL_FRAC_BITS = hvn_pkg::NORMAL_FRAC_DEF
) (
	input logic     clk,
	input logic     arst_n,
	hvn_cfg_if.sink cfg,
	hvn_in_if.sink  heights,
	hvn_out_if.source normal
);
	import hvn_pkg::*;

	localparam int DIFF_W = HEIGHT_W + 1;
	localparam int SP_X_W = SPACING_W + 1;
	localparam int UNIT_W = UNIT_FRAC + 2;
	localparam int NRM_OUT_W = NORMAL_FRAC_BITS + 2;

	// Configuration registers. Writes are accepted in every cycle; an index outside
	// the register list is dropped.
	logic [SPACING_W-1:0] x_spacing_q;
	logic [SPACING_W-1:0] z_spacing_q;

	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			x_spacing_q <= SPACING_RESET;
			z_spacing_q <= SPACING_RESET;
		end else if (cfg.valid && cfg.ready) begin
			unique case (cfg.index)
				REG_X_SPACING: x_spacing_q <= cfg.data;
				REG_Z_SPACING: z_spacing_q <= cfg.data;
				default: ;
			endcase
		end
	end

	// The whole pipeline advances together. It only stops while the skid register
	// holds a result that the sink has not taken, so ready never depends on the
	// sink's ready in the same cycle.
	logic en;
	logic skid_valid_q;
	assign en = !skid_valid_q;
	assign heights.ready = en;

	// Stage 1: height differences against the center and spacings, with a zero
	// spacing treated as the smallest step.
	logic                    v_s1;
	logic signed [DIFF_W-1:0] de_s1, dn_s1, dw_s1, ds_s1;
	logic [SPACING_W-1:0]    xs_s1, zs_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s1 <= 1'b0;
		else if (en) v_s1 <= heights.valid;
	end
	always_ff @(posedge clk) begin
		if (en) begin
			de_s1 <= DIFF_W'(heights.height_east)  - DIFF_W'(heights.height_center);
			dn_s1 <= DIFF_W'(heights.height_north) - DIFF_W'(heights.height_center);
			dw_s1 <= DIFF_W'(heights.height_west)  - DIFF_W'(heights.height_center);
			ds_s1 <= DIFF_W'(heights.height_south) - DIFF_W'(heights.height_center);
			xs_s1 <= (x_spacing_q == '0) ? SPACING_W'(1) : x_spacing_q;
			zs_s1 <= (z_spacing_q == '0) ? SPACING_W'(1) : z_spacing_q;
		end
	end

	// Stage 2: the distinct cross-product terms. The edge vectors are east (X,dE,0),
	// north (0,dN,-Z), west (-X,dW,0) and south (0,dS,Z); every product's y term is X*Z.
	logic   v_s2;
	vcomp_t ex_s2, wx_s2, nz_s2, sz_s2, xz_s2;
	logic signed [SP_X_W-1:0] xs_x, zs_x;
	assign xs_x = $signed({1'b0, xs_s1});
	assign zs_x = $signed({1'b0, zs_s1});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s2 <= 1'b0;
		else if (en) v_s2 <= v_s1;
	end
	always_ff @(posedge clk) begin
		if (en) begin
			ex_s2 <= -(vcomp_t'(de_s1) * vcomp_t'(zs_x));
			wx_s2 <= vcomp_t'(dw_s1) * vcomp_t'(zs_x);
			nz_s2 <= vcomp_t'(dn_s1) * vcomp_t'(xs_x);
			sz_s2 <= -(vcomp_t'(ds_s1) * vcomp_t'(xs_x));
			xz_s2 <= vcomp_t'(xs_x) * vcomp_t'(zs_x);
		end
	end

	// Four face normals, east-north, north-west, west-south and south-east,
	// each normalized in its own pipeline with 30 fraction bits.
	vcomp_t face [4][3];
	assign face[0] = '{ex_s2, xz_s2, nz_s2};
	assign face[1] = '{wx_s2, xz_s2, nz_s2};
	assign face[2] = '{wx_s2, xz_s2, sz_s2};
	assign face[3] = '{ex_s2, xz_s2, sz_s2};

	logic                    face_valid [4];
	logic signed [UNIT_W-1:0] unit_vec [4][3];

	for (genvar k = 0; k < 4; k++) begin : g_face
		hvn_unitize #(
			.FRAC (UNIT_FRAC)
		) u_face (
			.clk       (clk),
			.arst_n    (arst_n),
			.en        (en),
			.in_valid  (v_s2),
			.in_vec    (face[k]),
			.out_valid (face_valid[k]),
			.out_vec   (unit_vec[k])
		);
	end

	// Sum of the four unit face normals.
	logic   v_sum_s3;
	vcomp_t sum_s3 [3];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_sum_s3 <= 1'b0;
		else if (en) v_sum_s3 <= face_valid[0];
	end
	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < 3; i++)
				sum_s3[i] <= vcomp_t'(unit_vec[0][i]) + vcomp_t'(unit_vec[1][i]) +
					vcomp_t'(unit_vec[2][i]) + vcomp_t'(unit_vec[3][i]);
		end
	end

	// Final normalization to the output fraction width.
	logic                        fin_valid;
	logic signed [NRM_OUT_W-1:0] fin_vec [3];

	hvn_unitize #(
		.FRAC (NORMAL_FRAC_BITS)
	) u_final (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.in_valid  (v_sum_s3),
		.in_vec    (sum_s3),
		.out_valid (fin_valid),
		.out_vec   (fin_vec)
	);

	// Components are sign-extended or cut to the 16-bit result fields.
	logic signed [RAD_W-1:0] fin_wide [3];
	always_comb begin
		for (int i = 0; i < 3; i++)
			fin_wide[i] = RAD_W'(fin_vec[i]);
	end

	// Output skid register: catches the result leaving the pipeline when the sink
	// stalls, and presents it until it is taken.
	normal_t skid_x_q, skid_y_q, skid_z_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			skid_valid_q <= 1'b0;
		end else if (skid_valid_q) begin
			if (normal.ready) skid_valid_q <= 1'b0;
		end else if (fin_valid && !normal.ready) begin
			skid_valid_q <= 1'b1;
		end
	end
	always_ff @(posedge clk) begin
		if (!skid_valid_q) begin
			skid_x_q <= fin_wide[0][NORMAL_W-1:0];
			skid_y_q <= fin_wide[1][NORMAL_W-1:0];
			skid_z_q <= fin_wide[2][NORMAL_W-1:0];
		end
	end

	assign normal.valid    = skid_valid_q || fin_valid;
	assign normal.normal_x = skid_valid_q ? skid_x_q : fin_wide[0][NORMAL_W-1:0];
	assign normal.normal_y = skid_valid_q ? skid_y_q : fin_wide[1][NORMAL_W-1:0];
	assign normal.normal_z = skid_valid_q ? skid_z_q : fin_wide[2][NORMAL_W-1:0];

endmodule

// ----- test/heightmap_vertex_normal_unit_tb.sv -----
`timescale 1ns / 1ps
// Self-checking testbench for heightmap_vertex_normal_unit: drives height requests and
// spacing writes, predicts each unit normal bit for bit and compares it with the block.
// Depends on hvn_pkg, hvn_ifs and the unit's RTL.

import hvn_pkg::*;

// Predicts normals from the current spacings and keeps the normals still owed by the block.
class normal_scoreboard;
	typedef struct {
		normal_t nx;
		normal_t ny;
		normal_t nz;
	} normal_s;

	normal_s owed[$];
	longint x_step;
	longint z_step;
	int errors;

	function new();
		x_step = 256;
		z_step = 256;
		errors = 0;
	endfunction

	function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
		if (idx == REG_X_SPACING) begin
			x_step = longint'(data);
		end else if (idx == REG_Z_SPACING) begin
			z_step = longint'(data);
		end
	endfunction

	// Bitwise integer square root, floor.
	function automatic longint unsigned root_floor(longint unsigned s);
		longint unsigned res;
		longint unsigned b;
		res = 0;
		b = 64'd1 << 62;
		while (b > s)
			b >>= 2;
		while (b != 0) begin
			if (s >= res + b) begin
				s -= res + b;
				res = (res >> 1) + b;
			end else begin
				res >>= 1;
			end
			b >>= 2;
		end
		return res;
	endfunction

	// Scales a vector to unit length with frac fraction bits, rounding each quotient.
	function automatic void unit_vec(input longint v[3], input int frac, output longint o[3]);
		longint unsigned m[3];
		bit neg[3];
		longint unsigned mx, s, r, one, q;
		int rt, lf;
		mx = 0;
		s = 0;
		rt = 0;
		lf = 0;
		one = 64'd1 << frac;
		for (int i = 0; i < 3; i++) begin
			neg[i] = v[i] < 0;
			m[i] = neg[i] ? longint'(0) - v[i] : v[i];
			if (m[i] > mx)
				mx = m[i];
		end
		if (mx == 0) begin
			o[0] = 0;
			o[1] = longint'(one);
			o[2] = 0;
			return;
		end
		while (mx >= (64'd1 << 31)) begin
			mx >>= 1;
			rt++;
		end
		while (mx < (64'd1 << 30)) begin
			mx <<= 1;
			lf++;
		end
		for (int i = 0; i < 3; i++) begin
			m[i] = (m[i] >> rt) << lf;
			s += m[i] * m[i];
		end
		r = root_floor(s);
		for (int i = 0; i < 3; i++) begin
			q = ((m[i] << frac) + (r >> 1)) / r;
			if (q > one)
				q = one;
			o[i] = neg[i] ? -longint'(q) : longint'(q);
		end
	endfunction

	function void note_request(height_t h[5]);
		longint hc, de, dn, dw, ds, xs, zs, xz;
		longint cr[4][3];
		longint u[3];
		longint acc[3];
		longint n[3];
		normal_s e;
		hc = longint'(h[0]);
		de = longint'(h[1]) - hc;
		dn = longint'(h[2]) - hc;
		dw = longint'(h[3]) - hc;
		ds = longint'(h[4]) - hc;
		// A spacing of zero is treated as the smallest step.
		xs = (x_step != 0) ? x_step : 1;
		zs = (z_step != 0) ? z_step : 1;
		xz = xs * zs;
		cr[0] = '{-de * zs, xz, xs * dn};
		cr[1] = '{zs * dw, xz, xs * dn};
		cr[2] = '{zs * dw, xz, -xs * ds};
		cr[3] = '{-de * zs, xz, -xs * ds};
		acc = '{0, 0, 0};
		for (int k = 0; k < 4; k++) begin
			unit_vec(cr[k], UNIT_FRAC, u);
			for (int i = 0; i < 3; i++)
				acc[i] += u[i];
		end
		unit_vec(acc, NORMAL_FRAC_DEF, n);
		e.nx = normal_t'(n[0]);
		e.ny = normal_t'(n[1]);
		e.nz = normal_t'(n[2]);
		owed.push_back(e);
	endfunction

	function void check_result(normal_t nx, normal_t ny, normal_t nz);
		normal_s e;
		if (owed.size() == 0) begin
			$display("%0t: unexpected normal (%0d, %0d, %0d)", $time, nx, ny, nz);
			errors++;
			return;
		end
		e = owed.pop_front();
		if (nx !== e.nx) begin
			$display("%0t: normal_x expected %0d actual %0d", $time, e.nx, nx);
			errors++;
		end
		if (ny !== e.ny) begin
			$display("%0t: normal_y expected %0d actual %0d", $time, e.ny, ny);
			errors++;
		end
		if (nz !== e.nz) begin
			$display("%0t: normal_z expected %0d actual %0d", $time, e.nz, nz);
			errors++;
		end
	endfunction

	function int pending();
		return owed.size();
	endfunction
endclass

module heightmap_vertex_normal_unit_tb;
	// Only indexes 0 and 1 exist; this one must be ignored by the block.
	localparam logic [CFG_IDX_W-1:0] REG_UNUSED = CFG_IDX_W'(2);
	// The drain wait covers a full pipeline with margin.
	localparam int DRAIN_CYCLES = 200;
	// The longest legal silence is the long receiver hold-off plus a full pipeline.
	localparam int HOLD_CYCLES = 400;
	localparam int WATCHDOG_LIMIT = 3000;

	logic clk;
	logic arst_n;

	hvn_cfg_if cfg ();
	hvn_in_if heights ();
	hvn_out_if normal ();

	heightmap_vertex_normal_unit dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg(cfg.sink),
		.heights(heights.source),
		.normal(normal.sink)
	);

	normal_scoreboard sb = new();

	// When quiet is set neither side idles; hold_req asks the receiver for one long hold-off.
	bit quiet = 0;
	bit hold_req = 0;

	initial begin
		clk = 0;
		forever #5 clk = ~clk;
	end

	// Every accepted normal is checked against the oldest prediction.
	always @(posedge clk) begin
		if (arst_n && normal.valid && normal.ready)
			sb.check_result(normal.normal_x, normal.normal_y, normal.normal_z);
	end

	// The receiver picks ready or stall at random for bursts of random length. On request it holds off
	// long enough for the pipeline to fill and the block to stall its input.
	initial begin
		int n;
		normal.ready = 0;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (hold_req) begin
				normal.ready <= 1'b0;
				for (int i = 0; i < HOLD_CYCLES; i++)
					@(posedge clk);
				hold_req = 0;
				normal.ready <= 1'b1;
			end else if (quiet) begin
				normal.ready <= 1'b1;
			end else begin
				n = $urandom_range(1, 16);
				normal.ready <= $urandom_range(0, 1);
				repeat (n - 1) @(posedge clk);
			end
		end
	end

	// The watchdog ends the run when nothing at all moves for too long.
	initial begin
		int idle;
		idle = 0;
		forever begin
			@(posedge clk);
			if ((heights.valid && heights.ready) || (normal.valid && normal.ready) ||
				(cfg.valid && cfg.ready))
				idle = 0;
			else
				idle++;
			if (idle >= WATCHDOG_LIMIT) begin
				$display("%0t: timeout, no request or result moved", $time);
				$display("== FAIL ==");
				$finish;
			end
		end
	end

	// Writes one spacing register; called only while the block holds no request.
	task automatic write_spacing(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
		cfg.valid <= 1'b1;
		cfg.index <= idx;
		cfg.data <= data;
		do @(posedge clk); while (!cfg.ready);
		sb.write_reg(idx, data);
		cfg.valid <= 1'b0;
	endtask

	// Offers one height request and waits for its handshake. Valid stays high after
	// the handshake unless a random gap follows, so back-to-back requests stream.
	task automatic send_heights(height_t h[5]);
		heights.valid <= 1'b1;
		heights.height_center <= h[0];
		heights.height_east <= h[1];
		heights.height_north <= h[2];
		heights.height_west <= h[3];
		heights.height_south <= h[4];
		do @(posedge clk); while (!heights.ready);
		sb.note_request(h);
		if (!quiet && $urandom_range(0, 3) == 0) begin
			heights.valid <= 1'b0;
			repeat ($urandom_range(1, 16)) @(posedge clk);
		end
	endtask

	// Random heights: mostly gentle terrain around a random center, with fully random
	// points and rail-to-rail cliffs mixed in.
	task automatic random_heights(output height_t h[5]);
		int kind;
		height_t c;
		kind = $urandom_range(0, 9);
		c = height_t'($urandom);
		h[0] = c;
		for (int i = 1; i < 5; i++) begin
			if (kind < 5)
				h[i] = c + height_t'($urandom_range(0, 1024) - 512);
			else if (kind < 8)
				h[i] = height_t'($urandom);
			else
				h[i] = $urandom_range(0, 1) ? 16'sh7fff : -16'sh8000;
		end
	endtask

	task automatic drain();
		while (sb.pending() > 0)
			@(posedge clk);
	endtask

	task automatic random_phase(int count);
		height_t h[5];
		for (int i = 0; i < count; i++) begin
			random_heights(h);
			send_heights(h);
		end
		heights.valid <= 1'b0;
		drain();
	endtask

	initial begin
		height_t h[5];
		height_t hi, lo;
		hi = 16'sh7fff;
		lo = -16'sh8000;
		arst_n = 0;
		cfg.valid = 0;
		cfg.index = '0;
		cfg.data = '0;
		heights.valid = 0;
		heights.height_center = '0;
		heights.height_east = '0;
		heights.height_north = '0;
		heights.height_west = '0;
		heights.height_south = '0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed requests at the reset spacings: flat ground, the extremes, each
		// neighbor alone at either rail, and opposite neighbors pulling apart.
		send_heights('{0, 0, 0, 0, 0});
		send_heights('{hi, hi, hi, hi, hi});
		send_heights('{lo, lo, lo, lo, lo});
		send_heights('{lo, hi, hi, hi, hi});
		send_heights('{hi, lo, lo, lo, lo});
		for (int k = 1; k < 5; k++) begin
			h = '{0, 0, 0, 0, 0};
			h[k] = hi;
			send_heights(h);
			h[k] = lo;
			send_heights(h);
		end
		send_heights('{0, hi, 0, lo, 0});
		send_heights('{0, 0, hi, 0, lo});
		send_heights('{0, lo, hi, hi, lo});
		send_heights('{16'sh5555, -16'sh5556, 16'sh5555, -16'sh5556, 16'sh5555});
		send_heights('{-16'sh5556, 16'sh5555, -16'sh5556, 16'sh5555, -16'sh5556});
		heights.valid <= 1'b0;
		drain();

		// The receiver stops for a long stretch while requests keep coming.
		hold_req = 1;
		random_phase(200);

		// Smallest spacings, then a write to a missing register that must change nothing.
		write_spacing(REG_X_SPACING, 16'd1);
		write_spacing(REG_Z_SPACING, 16'd1);
		write_spacing(REG_UNUSED, 16'd4096);
		random_phase(150);

		// Largest spacings.
		write_spacing(REG_X_SPACING, 16'hffff);
		write_spacing(REG_Z_SPACING, 16'hffff);
		random_phase(150);

		// Very uneven grid both ways.
		write_spacing(REG_X_SPACING, 16'd1);
		write_spacing(REG_Z_SPACING, 16'hffff);
		random_phase(120);
		write_spacing(REG_X_SPACING, 16'hffff);
		write_spacing(REG_Z_SPACING, 16'd1);
		random_phase(120);

		// A spacing of zero behaves as the smallest step.
		write_spacing(REG_X_SPACING, 16'd0);
		write_spacing(REG_Z_SPACING, 16'd0);
		random_phase(100);

		// Random spacings, with the last stretch run without any idling.
		write_spacing(REG_X_SPACING, 16'($urandom));
		write_spacing(REG_Z_SPACING, 16'($urandom));
		random_phase(150);
		write_spacing(REG_X_SPACING, 16'($urandom_range(1, 1024)));
		write_spacing(REG_Z_SPACING, 16'($urandom_range(1, 1024)));
		quiet = 1;
		random_phase(150);

		repeat (DRAIN_CYCLES) @(posedge clk);
		if (sb.errors == 0 && sb.pending() == 0) begin
			$display("== PASS ==");
		end else begin
			$display("== FAIL ==");
		end
		$finish;
	end
endmodule
